// File: src/u8dec_pkg.sv
// u8dec_pkg: shared widths, lead-byte ranges and field types for the UTF-8 stream decoder.
// No dependencies; compiled first.

package u8dec_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int CP_BITS        = 21;
   localparam int LEN_BITS       = 3;
   localparam int LEFT_BITS      = 2;
   localparam int COUNT_BITS     = 16;  // internal character counter, 8..32
   localparam int OUT_COUNT_BITS = 16;  // presented width of char_count
   localparam int CONT_BITS      = 6;   // payload bits per continuation byte

   typedef logic [BYTE_BITS-1:0]      byte_val_type;
   typedef logic [CP_BITS-1:0]        code_point_type;
   typedef logic [LEN_BITS-1:0]       seq_len_type;
   typedef logic [LEFT_BITS-1:0]      left_type;
   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [OUT_COUNT_BITS-1:0] out_count_type;

   localparam byte_val_type NUL_BYTE  = 8'h00;
   localparam byte_val_type ASCII_MAX = 8'h7F;
   localparam byte_val_type LEAD2_LO  = 8'hC2;
   localparam byte_val_type LEAD2_HI  = 8'hDF;
   localparam byte_val_type LEAD3_LO  = 8'hE0;
   localparam byte_val_type LEAD3_HI  = 8'hEF;
   localparam byte_val_type LEAD4_LO  = 8'hF0;
   localparam byte_val_type LEAD4_HI  = 8'hF4;

   localparam seq_len_type LEN_NONE = 3'd0;
   localparam seq_len_type LEN_ONE  = 3'd1;
   localparam seq_len_type LEN_TWO  = 3'd2;
   localparam seq_len_type LEN_THREE = 3'd3;
   localparam seq_len_type LEN_FOUR = 3'd4;

   localparam left_type LEFT_NONE  = 2'd0;
   localparam left_type LEFT_ONE   = 2'd1;
   localparam left_type LEFT_TWO   = 2'd2;
   localparam left_type LEFT_THREE = 2'd3;

endpackage

// File: src/u8dec_if.sv
// u8dec_req_if / u8dec_rsp_if: valid/ready channels for raw bytes and decoded characters.
// Depends on u8dec_pkg.

interface u8dec_req_if;
   import u8dec_pkg::*;

   logic         valid;
   logic         ready;
   byte_val_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8dec_rsp_if;
   import u8dec_pkg::*;

   logic           valid;
   logic           ready;
   code_point_type code_point;
   seq_len_type    seq_length;
   logic           bad_lead;
   logic           end_of_string;
   out_count_type  char_count;

   modport source (output valid, output code_point, output seq_length, output bad_lead,
                   output end_of_string, output char_count, input ready);
   modport sink   (input valid, input code_point, input seq_length, input bad_lead,
                   input end_of_string, input char_count, output ready);
endinterface

// File: src/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: byte-serial UTF-8 decoder with per-string character count.
// Depends on u8dec_pkg and the channel interfaces in u8dec_if.sv.
//
//   channel   dir   width               contents
//   req_if    in    8                   raw text byte
//   rsp_if    out   21+3+1+1+16         code point, length, bad lead, end of string, count
//
// One byte per cycle sustained while the result is not stalled: a byte register feeds
// the classify/shift-accumulate logic, which writes the result register and the decoder
// state in the same cycle. A byte passes the byte register, then the result register.
// Synchronous active-high reset clears the valid flags of both stages and all decoder state.
// A stalled result stops the byte stage; one more byte is taken into the empty stage.

module utf8_stream_decoder_top (
   input logic clock,
   input logic reset,
   u8dec_req_if.sink   req_if,
   u8dec_rsp_if.source rsp_if
);
   import u8dec_pkg::*;

   // byte stage
   logic           in_valid_ff, in_valid_in;
   byte_val_type   in_byte_ff;

   // decoder state
   code_point_type partial_ff, partial_in;
   left_type       left_ff, left_in;
   seq_len_type    seq_total_ff, seq_total_in;
   count_type      count_ff, count_in;

   // result stage
   logic           rsp_valid_ff, rsp_valid_in;
   code_point_type cp_ff, cp_in;
   seq_len_type    len_ff, len_in;
   logic           bad_ff, bad_in;
   logic           eos_ff, eos_in;
   out_count_type  ocount_ff, ocount_in;

   logic           out_free;
   logic           advance;
   logic           req_take;
   code_point_type shifted;
   count_type      count_inc;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take = req_if.valid && req_if.ready;

   assign shifted   = {partial_ff[CP_BITS-CONT_BITS-1:0], in_byte_ff[CONT_BITS-1:0]};
   assign count_inc = count_ff + count_type'(1);

   always_comb begin
      partial_in   = partial_ff;
      left_in      = left_ff;
      seq_total_in = seq_total_ff;
      count_in     = count_ff;
      cp_in        = '0;
      len_in       = LEN_NONE;
      bad_in       = 1'b0;
      eos_in       = 1'b0;
      ocount_in    = OUT_COUNT_BITS'(count_inc);
      rsp_valid_in = 1'b0;

      if (left_ff != LEFT_NONE) begin
         left_in = left_ff - LEFT_ONE;
         if (left_ff == LEFT_ONE) begin
            count_in     = count_inc;
            cp_in        = shifted;
            len_in       = seq_total_ff;
            rsp_valid_in = 1'b1;
            partial_in   = '0;
            seq_total_in = LEN_NONE;
         end else begin
            partial_in = shifted;
         end
      end else begin
         case (in_byte_ff) inside
            NUL_BYTE: begin
               eos_in       = 1'b1;
               ocount_in    = OUT_COUNT_BITS'(count_ff);
               rsp_valid_in = 1'b1;
               count_in     = '0;
               partial_in   = '0;
               seq_total_in = LEN_NONE;
            end
            [8'h01:ASCII_MAX]: begin
               count_in     = count_inc;
               cp_in        = CP_BITS'(in_byte_ff);
               len_in       = LEN_ONE;
               rsp_valid_in = 1'b1;
            end
            [LEAD2_LO:LEAD2_HI]: begin
               partial_in   = CP_BITS'(in_byte_ff[4:0]);
               left_in      = LEFT_ONE;
               seq_total_in = LEN_TWO;
            end
            [LEAD3_LO:LEAD3_HI]: begin
               partial_in   = CP_BITS'(in_byte_ff[3:0]);
               left_in      = LEFT_TWO;
               seq_total_in = LEN_THREE;
            end
            [LEAD4_LO:LEAD4_HI]: begin
               partial_in   = CP_BITS'(in_byte_ff[2:0]);
               left_in      = LEFT_THREE;
               seq_total_in = LEN_FOUR;
            end
            default: begin
               // stray continuation, overlong or out-of-range lead
               count_in     = count_inc;
               cp_in        = CP_BITS'(in_byte_ff[6:0]);
               len_in       = LEN_ONE;
               bad_in       = 1'b1;
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         partial_ff   <= '0;
         left_ff      <= LEFT_NONE;
         seq_total_ff <= LEN_NONE;
         count_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            rsp_valid_ff <= rsp_valid_in;
            partial_ff   <= partial_in;
            left_ff      <= left_in;
            seq_total_ff <= seq_total_in;
            count_ff     <= count_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.in_byte;
      end
      if (advance) begin
         cp_ff     <= cp_in;
         len_ff    <= len_in;
         bad_ff    <= bad_in;
         eos_ff    <= eos_in;
         ocount_ff <= ocount_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.code_point    = cp_ff;
   assign rsp_if.seq_length    = len_ff;
   assign rsp_if.bad_lead      = bad_ff;
   assign rsp_if.end_of_string = eos_ff;
   assign rsp_if.char_count    = ocount_ff;

   // a multi-byte character in progress always knows a total longer than what remains
   a_seq_total_consistent: assert property (@(posedge clock) disable iff (reset)
      left_ff != LEFT_NONE |-> (seq_total_ff > seq_len_type'(left_ff)) &&
                               (seq_total_ff <= LEN_FOUR))
      else $error("seq_total inconsistent with bytes left");

   a_eos_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && eos_ff |-> cp_ff == '0 && len_ff == LEN_NONE && !bad_ff)
      else $error("end-of-string result carries character fields");

   a_char_has_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !eos_ff |-> len_ff != LEN_NONE)
      else $error("character result with zero length");

   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bad_ff |-> len_ff == LEN_ONE && cp_ff[CP_BITS-1:7] == '0)
      else $error("bad lead result not a single 7-bit character");

   a_idle_between_chars: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_valid_in |=> left_ff == LEFT_NONE && partial_ff == '0 ||
                                 !$past(eos_in) && $past(left_ff) == LEFT_NONE)
      else $error("decoder state not idle after a completed character");

endmodule
